// ===== hw/rtl/sbbm_pkg.sv =====
// Shared types and constants for the slice bounding-box border mask block.
// No dependencies; every other file refers to it by scoped names.
package sbbm_pkg;

  localparam int CFG_W          = 11;
  localparam int COORD_W        = 10;
  localparam int MASK_W         = 8;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int DEF_MAX_SIDE   = 1024;
  localparam int DEF_VOXEL_BITS = 16;

  localparam logic [CFG_W-1:0]  CFG_RESET    = 11'd1024;
  localparam logic [MASK_W-1:0] MASK_OUTSIDE = 8'd255;
  localparam logic [MASK_W-1:0] MASK_INSIDE  = 8'd0;

  typedef enum logic [0:0] {
    REG_SLICE_WIDTH  = 1'b0,
    REG_SLICE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_MEASURE = 1'b0,
    OP_MASK    = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [MASK_W-1:0]  mask_value;
    logic               slice_empty;
    logic [COORD_W-1:0] first_row;
    logic [COORD_W-1:0] last_row;
    logic [COORD_W-1:0] first_col;
    logic [COORD_W-1:0] last_col;
    logic               end_of_slice;
  } res_t;

endpackage

// ===== hw/rtl/slice_bounding_box_border_mask.sv =====
// Top level of the slice bounding-box border mask block: input register,
// result register, and the sbbm_cfg / sbbm_core instances. Depends on sbbm_pkg.
//
// Usage: write slice_width and slice_height over APB (byte addresses 0 and 4)
// while the block is idle. Stream a slice's voxels row-major with opcode
// measure; the beat for the final position yields one result carrying the
// box, slice_empty and end_of_slice. Then stream one opcode-mask beat per
// position; each yields one result with mask_value 0 inside the box and 255
// outside (all 255 for an empty slice). The box clears after the last mask
// beat; measure passes without a mask pass in between merge their boxes.
// A beat passes through the input register, then the result register, before
// its result appears on out_valid. Throughput is one beat per cycle unless a
// stalled result blocks it, set by the combinational box update in between.
// Reset: position and box clear, both size registers read 1024.
// While out_stall holds a waiting result, the input register drains no beat,
// not even a measure beat that yields no result, so in_stall rises as soon as
// the input register is occupied and blocked.
module slice_bounding_box_border_mask #(
  parameter int MAX_SIDE   = sbbm_pkg::DEF_MAX_SIDE,
  parameter int VOXEL_BITS = sbbm_pkg::DEF_VOXEL_BITS,
  localparam int POS_W     = $clog2(MAX_SIDE)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbbm_pkg::PADDR_W-1:0]  paddr,
  input  logic [sbbm_pkg::PDATA_W-1:0]  pwdata,
  output logic [sbbm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [VOXEL_BITS-1:0]         voxel_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbbm_pkg::MASK_W-1:0]   mask_value,
  output logic                          slice_empty,
  output logic [sbbm_pkg::COORD_W-1:0]  first_row,
  output logic [sbbm_pkg::COORD_W-1:0]  last_row,
  output logic [sbbm_pkg::COORD_W-1:0]  first_col,
  output logic [sbbm_pkg::COORD_W-1:0]  last_col,
  output logic                          end_of_slice
);

  logic              in_reg_valid;
  sbbm_pkg::opcode_t in_op;
  logic [VOXEL_BITS-1:0] in_voxel;
  logic              proceed;
  logic              in_accept;

  logic [POS_W-1:0]  width_m1;
  logic [POS_W-1:0]  height_m1;
  logic              has_result;
  sbbm_pkg::res_t    core_res;
  sbbm_pkg::res_t    out_res;

  sbbm_cfg #(.MAX_SIDE(MAX_SIDE)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .width_m1  (width_m1),
    .height_m1 (height_m1)
  );

  sbbm_core #(.MAX_SIDE(MAX_SIDE)) u_core (
    .clk        (clk),
    .rst        (rst),
    .proc_en    (proceed),
    .op         (in_op),
    .nonzero    (|in_voxel),
    .width_m1   (width_m1),
    .height_m1  (height_m1),
    .has_result (has_result),
    .res        (core_res)
  );

  // advance the held beat only when the result register is free or draining
  assign proceed   = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall  = in_reg_valid && !proceed;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_reg_valid || proceed) begin
      in_reg_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_op    <= sbbm_pkg::opcode_t'(opcode);
      in_voxel <= voxel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      out_res <= core_res;
    end
  end

  assign mask_value   = out_res.mask_value;
  assign slice_empty  = out_res.slice_empty;
  assign first_row    = out_res.first_row;
  assign last_row     = out_res.last_row;
  assign first_col    = out_res.first_col;
  assign last_col     = out_res.last_col;
  assign end_of_slice = out_res.end_of_slice;

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && in_reg_valid))
    else $error("input stalled without a blocked result");

  a_empty_mask: assert property (@(posedge clk) disable iff (rst)
    (out_valid && slice_empty) |->
      (mask_value == sbbm_pkg::MASK_OUTSIDE || end_of_slice))
    else $error("empty slice produced an inside mask");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !slice_empty) |->
      ((MAX_SIDE > 1024) || (first_row <= last_row && first_col <= last_col)))
    else $error("box bounds out of order");

  a_measure_mask: assert property (@(posedge clk) disable iff (rst)
    (proceed && in_op == sbbm_pkg::OP_MEASURE) |=>
      (!out_valid || (end_of_slice && mask_value == sbbm_pkg::MASK_INSIDE)))
    else $error("measure beat produced a stray result");

endmodule

// ===== hw/rtl/sbbm_cfg.sv =====
// APB register file for slice width and height, with clamping to 1..MAX_SIDE.
// Depends on sbbm_pkg.
module sbbm_cfg #(
  parameter int MAX_SIDE = sbbm_pkg::DEF_MAX_SIDE,
  localparam int POS_W   = $clog2(MAX_SIDE)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbbm_pkg::PADDR_W-1:0] paddr,
  input  logic [sbbm_pkg::PDATA_W-1:0] pwdata,
  output logic [sbbm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [POS_W-1:0]            width_m1,
  output logic [POS_W-1:0]            height_m1
);

  localparam logic [31:0] MAX32 = 32'(MAX_SIDE);

  logic [sbbm_pkg::CFG_W-1:0] slice_width;
  logic [sbbm_pkg::CFG_W-1:0] slice_height;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_width  <= sbbm_pkg::CFG_RESET;
      slice_height <= sbbm_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (sbbm_pkg::reg_idx_t'(paddr[2]))
        sbbm_pkg::REG_SLICE_WIDTH:  slice_width  <= pwdata[sbbm_pkg::CFG_W-1:0];
        sbbm_pkg::REG_SLICE_HEIGHT: slice_height <= pwdata[sbbm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sbbm_pkg::reg_idx_t'(paddr[2]))
      sbbm_pkg::REG_SLICE_WIDTH:  prdata = sbbm_pkg::PDATA_W'(slice_width);
      sbbm_pkg::REG_SLICE_HEIGHT: prdata = sbbm_pkg::PDATA_W'(slice_height);
      default: prdata = '0;
    endcase
  end

  // zero acts as one, anything past MAX_SIDE acts as MAX_SIDE
  function automatic logic [POS_W-1:0] side_m1(input logic [sbbm_pkg::CFG_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0)      side_m1 = '0;
    else if (v32 > MAX32)  side_m1 = POS_W'(MAX32 - 32'd1);
    else                   side_m1 = POS_W'(v32 - 32'd1);
  endfunction

  assign width_m1  = side_m1(slice_width);
  assign height_m1 = side_m1(slice_height);

endmodule

// ===== hw/rtl/sbbm_core.sv =====
// Position counter and bounding-box state; forms a result for every mask beat and the final-position beat.
// Depends on sbbm_pkg.
module sbbm_core #(
  parameter int MAX_SIDE = sbbm_pkg::DEF_MAX_SIDE,
  localparam int POS_W   = $clog2(MAX_SIDE)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                proc_en,
  input  sbbm_pkg::opcode_t   op,
  input  logic                nonzero,
  input  logic [POS_W-1:0]    width_m1,
  input  logic [POS_W-1:0]    height_m1,
  output logic                has_result,
  output sbbm_pkg::res_t      res
);

  logic [POS_W-1:0] col_position, col_position_next;
  logic [POS_W-1:0] row_position, row_position_next;
  logic             box_valid, box_valid_next;
  logic [POS_W-1:0] box_row_min, box_row_min_next;
  logic [POS_W-1:0] box_row_max, box_row_max_next;
  logic [POS_W-1:0] box_col_min, box_col_min_next;
  logic [POS_W-1:0] box_col_max, box_col_max_next;

  logic             col_wrap;
  logic             last;
  logic             upd_valid;
  logic [POS_W-1:0] upd_rmin, upd_rmax, upd_cmin, upd_cmax;
  logic             pos_in_box;

  assign col_wrap = col_position >= width_m1;
  assign last     = col_wrap && (row_position >= height_m1);

  always_comb begin
    if (col_wrap) begin
      col_position_next = '0;
      row_position_next = last ? '0 : row_position + POS_W'(1);
    end else begin
      col_position_next = col_position + POS_W'(1);
      row_position_next = row_position;
    end
  end

  // box after folding in a measured voxel
  always_comb begin
    upd_valid = box_valid;
    upd_rmin  = box_row_min;
    upd_rmax  = box_row_max;
    upd_cmin  = box_col_min;
    upd_cmax  = box_col_max;
    if (op == sbbm_pkg::OP_MEASURE && nonzero) begin
      upd_valid = 1'b1;
      if (!box_valid) begin
        upd_rmin = row_position;
        upd_rmax = row_position;
        upd_cmin = col_position;
        upd_cmax = col_position;
      end else begin
        if (row_position < box_row_min) upd_rmin = row_position;
        if (row_position > box_row_max) upd_rmax = row_position;
        if (col_position < box_col_min) upd_cmin = col_position;
        if (col_position > box_col_max) upd_cmax = col_position;
      end
    end
  end

  assign pos_in_box = box_valid &&
                      row_position >= box_row_min && row_position <= box_row_max &&
                      col_position >= box_col_min && col_position <= box_col_max;

  always_comb begin
    has_result = (op == sbbm_pkg::OP_MASK) || last;
    res.mask_value   = (op == sbbm_pkg::OP_MEASURE || pos_in_box) ?
                       sbbm_pkg::MASK_INSIDE : sbbm_pkg::MASK_OUTSIDE;
    res.slice_empty  = !upd_valid;
    res.first_row    = sbbm_pkg::COORD_W'(upd_rmin);
    res.last_row     = sbbm_pkg::COORD_W'(upd_rmax);
    res.first_col    = sbbm_pkg::COORD_W'(upd_cmin);
    res.last_col     = sbbm_pkg::COORD_W'(upd_cmax);
    res.end_of_slice = last;
  end

  // clear the box when a mask pass ends
  always_comb begin
    if (op == sbbm_pkg::OP_MASK && last) begin
      box_valid_next   = 1'b0;
      box_row_min_next = '0;
      box_row_max_next = '0;
      box_col_min_next = '0;
      box_col_max_next = '0;
    end else begin
      box_valid_next   = upd_valid;
      box_row_min_next = upd_rmin;
      box_row_max_next = upd_rmax;
      box_col_min_next = upd_cmin;
      box_col_max_next = upd_cmax;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_position <= '0;
      row_position <= '0;
      box_valid    <= 1'b0;
      box_row_min  <= '0;
      box_row_max  <= '0;
      box_col_min  <= '0;
      box_col_max  <= '0;
    end else if (proc_en) begin
      col_position <= col_position_next;
      row_position <= row_position_next;
      box_valid    <= box_valid_next;
      box_row_min  <= box_row_min_next;
      box_row_max  <= box_row_max_next;
      box_col_min  <= box_col_min_next;
      box_col_max  <= box_col_max_next;
    end
  end

endmodule
